/* src/bled_pkg.sv */
// Package for bearing_to_led_ring_mask: word types, fixed-point constants, tables.
package bled_pkg;

    // Fixed coordinate width of the input words
    localparam int COORD_WIDTH      = 16;
    // Default number of CORDIC iterations (valid range 8..24)
    localparam int CORDIC_STEPS_DEF = 16;
    // Entries in the arctangent table
    localparam int ATAN_ENTRIES     = 24;
    // Fraction bits added below the coordinates
    localparam int GUARD_BITS       = 24;
    // Datapath width: coordinates, guard bits, CORDIC gain and sign headroom
    localparam int UV_W             = COORD_WIDTH + GUARD_BITS + 3;
    // Angle accumulator width, a full turn is 2^ACC_W
    localparam int ACC_W            = 32;
    localparam int BEARING_W        = 16;
    localparam int SECTOR_W         = 5;
    localparam int LED_COUNT        = 16;

    localparam logic [ACC_W-1:0]     HALF_TURN   = 32'h8000_0000;
    localparam logic [ACC_W-1:0]     ROUND_HALF  = 32'h0000_8000;
    localparam logic [BEARING_W-1:0] SECTOR_BIAS = 16'd1024;
    localparam logic [3:0]           FIRST_LED   = 4'd7;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_coord;
        logic signed [COORD_WIDTH-1:0] y_coord;
    } in_word_t;

    typedef struct packed {
        logic [LED_COUNT-1:0] led_mask;
        logic [SECTOR_W-1:0]  sector;
        logic [BEARING_W-1:0] bearing;
    } out_word_t;

    // atan(2^-i) as a fraction of a turn, 2^32 = 360 degrees
    function automatic logic [ACC_W-1:0] atan_turn(input logic [4:0] idx);
        logic [ACC_W-1:0] r;
        unique case (idx)
            5'd0:    r = 32'h2000_0000;
            5'd1:    r = 32'h12E4_051E;
            5'd2:    r = 32'h09FB_385B;
            5'd3:    r = 32'h0511_11D4;
            5'd4:    r = 32'h028B_0D43;
            5'd5:    r = 32'h0145_D7E1;
            5'd6:    r = 32'h00A2_F61E;
            5'd7:    r = 32'h0051_7C55;
            5'd8:    r = 32'h0028_BE53;
            5'd9:    r = 32'h0014_5F2F;
            5'd10:   r = 32'h000A_2F98;
            5'd11:   r = 32'h0005_17CC;
            5'd12:   r = 32'h0002_8BE6;
            5'd13:   r = 32'h0001_45F3;
            5'd14:   r = 32'h0000_A2FA;
            5'd15:   r = 32'h0000_517D;
            5'd16:   r = 32'h0000_28BE;
            5'd17:   r = 32'h0000_145F;
            5'd18:   r = 32'h0000_0A30;
            5'd19:   r = 32'h0000_0518;
            5'd20:   r = 32'h0000_028C;
            5'd21:   r = 32'h0000_0146;
            5'd22:   r = 32'h0000_00A3;
            5'd23:   r = 32'h0000_0051;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Ring mask for a sector: sector 0 lights LED 7, going down alternates
    // single LED and adjacent pair, wrapping from LED 15 to LED 0
    function automatic logic [LED_COUNT-1:0] sector_mask(input logic [SECTOR_W-1:0] s);
        logic [SECTOR_W-1:0]  k;
        logic [3:0]           p;
        logic [3:0]           p1;
        logic [LED_COUNT-1:0] m;
        k  = SECTOR_W'(0) - s;
        p  = FIRST_LED + k[4:1];
        p1 = p + 4'd1;
        m  = LED_COUNT'(1) << p;
        if (k[0]) begin
            m = m | (LED_COUNT'(1) << p1);
        end
        return m;
    endfunction

endpackage

/* src/bearing_to_led_ring_mask.sv */
// Top level: pipelined CORDIC bearing of an x,y vector and LED ring sector mask.
//
//  channel | ports                         | word        | direction
//  --------+-------------------------------+-------------+----------
//  input   | s_valid, s_ready, s_data      | in_word_t   | in
//  result  | m_valid, m_ready, m_data      | out_word_t  | out
//
// One word enters per cycle unless the result channel stalls. Stages:
// one prep stage (half-plane fold), one stage per CORDIC iteration, one output
// stage (rounding, sector, mask).
// Reset (aresetn, synchronous) clears all stage valid bits.
// Each stage holds its word while the stage after it is full and stalled;
// empty stages fill, so the input is taken while a result waits on m_ready.
module bearing_to_led_ring_mask #(
    parameter int CORDIC_STEPS = bled_pkg::CORDIC_STEPS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bled_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bled_pkg::out_word_t m_data
);
    import bled_pkg::*;

    localparam int N = CORDIC_STEPS;

    // Stage registers: index 0 is the prep stage, index k follows iteration k-1
    logic                    vld_reg  [0:N];
    logic                    zero_reg [0:N];
    logic signed [UV_W-1:0]  u_reg    [0:N];
    logic signed [UV_W-1:0]  v_reg    [0:N-1];
    logic [ACC_W-1:0]        acc_reg  [0:N];
    logic                    m_valid_reg;
    out_word_t               m_data_reg;

    // Stage can load when empty or when its content moves on
    logic                    rdy [0:N+1];

    assign rdy[N+1] = !m_valid_reg || m_ready;
    generate
        for (genvar j = 0; j <= N; j++) begin : g_rdy
            assign rdy[j] = !vld_reg[j] || rdy[j+1];
        end
    endgenerate
    assign s_ready = rdy[0];

    // Prep stage: scale, fold the lower half-plane by half a turn
    logic signed [UV_W-1:0] x_ext;
    logic signed [UV_W-1:0] y_ext;
    assign x_ext = UV_W'(s_data.x_coord) <<< GUARD_BITS;
    assign y_ext = UV_W'(s_data.y_coord) <<< GUARD_BITS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (rdy[0]) begin
            vld_reg[0] <= s_valid;
        end
        if (rdy[0]) begin
            zero_reg[0] <= (s_data.x_coord == '0) && (s_data.y_coord == '0);
            if (s_data.y_coord[COORD_WIDTH-1]) begin
                u_reg[0]   <= -y_ext;
                v_reg[0]   <= -x_ext;
                acc_reg[0] <= HALF_TURN;
            end else begin
                u_reg[0]   <= y_ext;
                v_reg[0]   <= x_ext;
                acc_reg[0] <= '0;
            end
        end
    end

    // CORDIC vectoring: one iteration per stage, drive v toward zero
    generate
        for (genvar k = 1; k <= N; k++) begin : g_iter
            logic signed [UV_W-1:0] du;
            logic signed [UV_W-1:0] dv;
            logic                   pos;
            logic [ACC_W-1:0]       ang;

            assign du  = v_reg[k-1] >>> (k-1);
            assign dv  = u_reg[k-1] >>> (k-1);
            assign pos = !v_reg[k-1][UV_W-1];
            assign ang = atan_turn(5'(k-1));

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
                if (rdy[k]) begin
                    zero_reg[k] <= zero_reg[k-1];
                    u_reg[k]    <= pos ? (u_reg[k-1] + du) : (u_reg[k-1] - du);
                    acc_reg[k]  <= pos ? (acc_reg[k-1] + ang) : (acc_reg[k-1] - ang);
                end
            end

            if (k < N) begin : g_v
                always_ff @(posedge aclk) begin
                    if (rdy[k]) begin
                        v_reg[k] <= pos ? (v_reg[k-1] - dv) : (v_reg[k-1] + dv);
                    end
                end
            end
        end
    endgenerate

    // Output stage: round to 16 bits, sector and ring mask
    logic [ACC_W-1:0]     acc_rnd;
    logic [BEARING_W-1:0] bearing_w;
    logic [BEARING_W-1:0] biased;
    logic [SECTOR_W-1:0]  sector_w;
    assign acc_rnd   = acc_reg[N] + ROUND_HALF;
    assign bearing_w = zero_reg[N] ? '0 : acc_rnd[ACC_W-1 -: BEARING_W];
    assign biased    = bearing_w + SECTOR_BIAS;
    assign sector_w  = biased[BEARING_W-1 -: SECTOR_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rdy[N+1]) begin
            m_valid_reg <= vld_reg[N];
        end
        if (rdy[N+1]) begin
            m_data_reg.bearing  <= bearing_w;
            m_data_reg.sector   <= sector_w;
            m_data_reg.led_mask <= sector_mask(sector_w);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    a_mask_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($countones(m_data.led_mask) == 1 || $countones(m_data.led_mask) == 2))
        else $error("led mask must light one or two LEDs");

    a_pair_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (($countones(m_data.led_mask) == 2) == m_data.sector[0]))
        else $error("LED pair must match odd sector");

    a_sector_bearing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.sector == SECTOR_W'((m_data.bearing + SECTOR_BIAS) >> 11)))
        else $error("sector does not follow bearing");

    a_u_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[N] && !zero_reg[N]) |-> !u_reg[N][UV_W-1])
        else $error("CORDIC magnitude went negative");

endmodule

/* tb/sv/bearing_ring_checker.sv */
// Checker for bearing_to_led_ring_mask: watches both channels, predicts each result word, compares.
module bearing_ring_checker #(
    parameter int CORDIC_STEPS = bled_pkg::CORDIC_STEPS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  bled_pkg::in_word_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  bled_pkg::out_word_t m_data,
    output int                  mismatch_count,
    output int                  pending_count
);
    import bled_pkg::*;

    // 1.0 in the coordinate fixed-point format (24 fraction bits)
    localparam longint FIX_ONE   = 64'sd16777216;
    localparam int     ATAN_SIZE = 24;

    // atan(2^-i) in turns, 2^32 per turn; entry 0 sits at the top
    localparam logic [32*ATAN_SIZE-1:0] ATAN_TURNS = {
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
    };

    out_word_t expected_words[$];

    // Bearing by CORDIC vectoring, then sector and ring mask
    function automatic out_word_t predict_ring_word(input in_word_t w);
        out_word_t   r;
        longint      u;
        longint      v;
        longint      du;
        longint      dv;
        logic [31:0] turn_acc;
        logic [31:0] rounded;
        logic [31:0] step_angle;
        logic [16:0] biased;
        int          k;
        int          p;
        turn_acc = '0;
        u = longint'(w.y_coord) * FIX_ONE;
        v = longint'(w.x_coord) * FIX_ONE;
        // origin stays at bearing 0
        if (w.x_coord != 0 || w.y_coord != 0) begin
            // fold the lower half-plane onto the upper one
            if (u < 0) begin
                u = -u;
                v = -v;
                turn_acc = 32'h8000_0000;
            end
            for (int i = 0; i < CORDIC_STEPS && i < ATAN_SIZE; i++) begin
                du = v >>> i;
                dv = u >>> i;
                step_angle = ATAN_TURNS[(ATAN_SIZE - 1 - i) * 32 +: 32];
                // zero residual counts as positive
                if (v >= 0) begin
                    u = u + du;
                    v = v - dv;
                    turn_acc = turn_acc + step_angle;
                end else begin
                    u = u - du;
                    v = v + dv;
                    turn_acc = turn_acc - step_angle;
                end
            end
        end
        // round to nearest; a full turn wraps to 0
        rounded   = turn_acc + 32'h0000_8000;
        r.bearing = rounded[31:16];
        // half-sector offset, 32 sectors
        biased   = {1'b0, r.bearing} + 17'd1024;
        r.sector = biased[15:11];
        // counting down from sector 0: single LED, then pair, wrapping at 15/0
        k = (32 - int'(r.sector)) % 32;
        p = 7 + k / 2;
        r.led_mask = '0;
        r.led_mask[p % 16] = 1'b1;
        if (k % 2 == 1) begin
            r.led_mask[(p + 1) % 16] = 1'b1;
        end
        return r;
    endfunction

    initial begin
        mismatch_count = 0;
        pending_count  = 0;
    end

    // Track accepted words on both channels
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_words.push_back(predict_ring_word(s_data));
            end
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word with nothing expected: %h", m_data);
                    mismatch_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_data.led_mask !== want.led_mask) begin
                        $error("led_mask: expected %h, got %h", want.led_mask, m_data.led_mask);
                        mismatch_count++;
                    end
                    if (m_data.sector !== want.sector) begin
                        $error("sector: expected %0d, got %0d", want.sector, m_data.sector);
                        mismatch_count++;
                    end
                    if (m_data.bearing !== want.bearing) begin
                        $error("bearing: expected %h, got %h", want.bearing, m_data.bearing);
                        mismatch_count++;
                    end
                end
            end
            pending_count = expected_words.size();
        end
    end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top for bearing_to_led_ring_mask: clock, reset, vector stimulus, verdict.
module tb_top;
    import bled_pkg::*;

    localparam int STEPS        = CORDIC_STEPS_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 1300;
    localparam int PHASES       = 4;
    localparam real TWO_PI      = 6.28318530718;

    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY} rx_mode_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    int       mismatch_count;
    int       pending_count;
    int       cycle_count  = 0;
    int       burst_left   = 0;
    int       tx_gap_max   = 6;
    rx_mode_t rx_mode      = RX_LIGHT;
    int       rx_hold_left = 0;

    bearing_to_led_ring_mask #(.CORDIC_STEPS(STEPS)) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    bearing_ring_checker #(.CORDIC_STEPS(STEPS)) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: alternating ready and stall runs of random length, or always ready in RX_FREE
    always @(posedge aclk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end else if (rx_mode == RX_FREE) begin
            m_ready <= 1'b1;
        end else if (m_ready) begin
            m_ready      <= 1'b0;
            rx_hold_left <= $urandom_range(0, (rx_mode == RX_HEAVY) ? 9 : 2);
        end else begin
            m_ready      <= 1'b1;
            rx_hold_left <= $urandom_range(0, 15);
        end
    end

    // Present one word, idling first when the current burst is used up
    task automatic send_vector(input int x, input int y);
        int       gap;
        in_word_t word;
        if (burst_left == 0) begin
            gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 48);
        end
        word.x_coord = x[15:0];
        word.y_coord = y[15:0];
        s_valid <= 1'b1;
        s_data  <= word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
    endtask

    // Stop sending until every expected word has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    function automatic int extreme_coord();
        case ($urandom_range(0, 4))
            0:       return -32768;
            1:       return -1;
            2:       return 0;
            3:       return 1;
            default: return 32767;
        endcase
    endfunction

    initial begin
        int  pick;
        int  rx;
        int  ry;
        int  sec;
        real ang;
        real radius;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: origin, axes, corners, unit steps, wrap to a full turn
        send_vector(0, 0);
        send_vector(0, 32767);
        send_vector(32767, 0);
        send_vector(0, -32768);
        send_vector(-32768, 0);
        send_vector(32767, 32767);
        send_vector(-32768, -32768);
        send_vector(32767, -32768);
        send_vector(-32768, 32767);
        send_vector(-1, 32767);
        send_vector(1, 32767);
        send_vector(0, 1);
        send_vector(0, -1);
        send_vector(-1, 0);
        send_vector(1, 0);
        send_vector(-1, -1);
        send_vector(1, -1);
        send_vector(-1, 1);
        send_vector(1, 1);
        send_vector(-32768, -1);
        send_vector(-32768, 1);
        send_vector(32767, -1);
        drain_results();

        // Random phases, each with its own idling profile
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin tx_gap_max = 6;  rx_mode = RX_LIGHT; end
                1: begin tx_gap_max = 0;  rx_mode = RX_FREE;  end
                2: begin tx_gap_max = 14; rx_mode = RX_HEAVY; end
                default: begin tx_gap_max = 3; rx_mode = RX_LIGHT; end
            endcase
            for (int n = 0; n < RANDOM_WORDS / PHASES; n++) begin
                pick = $urandom_range(0, 9);
                case (pick)
                    0, 1, 2, 3: begin
                        rx = $urandom_range(0, 65535);
                        ry = $urandom_range(0, 65535);
                    end
                    4: begin
                        rx = $urandom_range(0, 6) - 3;
                        ry = $urandom_range(0, 6) - 3;
                    end
                    5: begin
                        // one component zero
                        rx = $urandom_range(0, 65535);
                        ry = 0;
                        if ($urandom_range(0, 1) == 1) begin
                            ry = rx;
                            rx = 0;
                        end
                    end
                    6: begin
                        rx = extreme_coord();
                        ry = extreme_coord();
                    end
                    7: begin
                        // near a diagonal
                        rx = $urandom_range(0, 65535) - 32768;
                        ry = -rx + $urandom_range(0, 4) - 2;
                        if ($urandom_range(0, 1) == 1) begin
                            ry = rx + $urandom_range(0, 4) - 2;
                        end
                        if (ry > 32767) ry = 32767;
                        if (ry < -32768) ry = -32768;
                    end
                    default: begin
                        // close to a sector boundary
                        sec    = $urandom_range(0, 31);
                        ang    = TWO_PI * (sec * 2048 - 1024 + $urandom_range(0, 64) - 32)
                                 / 65536.0;
                        radius = $urandom_range(50, 32000);
                        rx     = $rtoi(radius * $sin(ang));
                        ry     = $rtoi(radius * $cos(ang));
                    end
                endcase
                send_vector(rx, ry);
            end
            drain_results();
        end

        // Let the pipeline settle before the verdict
        repeat (STEPS + 8) @(posedge aclk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
